@@ src/mrq_pkg.sv @@
package mrq_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BYTES = 64;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int BIDX_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int CNT_W = $clog2(SLOT_BYTES + 1);
	localparam int RING_W = $clog2(SLOT_COUNT + 1);
	localparam int RAM_DEPTH = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W = $clog2(RAM_DEPTH);

	localparam int CMD_W = 2;
	localparam int DATA_W = 8;
	localparam int LEN_W = 7;
	localparam int STATUS_W = 3;
	localparam int MCNT_W = 4;
	localparam int MMSG_W = 4;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BUF_SMALL = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [DATA_W-1:0] data;
		logic has_data;
		logic close;
		logic [LEN_W-1:0] max_bytes;
	} op_t;

	typedef struct packed {
		logic [MMSG_W-1:0] max_messages;
		logic [LEN_W-1:0] max_message_length;
	} cfg_t;

	function automatic logic [RING_W-1:0] ring_size(input logic [MMSG_W-1:0] mm);
		int n;
		n = int'(mm) + 1;
		if (n > SLOT_COUNT) begin
			return RING_W'(SLOT_COUNT);
		end
		return RING_W'(n);
	endfunction

	function automatic logic [CNT_W-1:0] length_limit(input logic [LEN_W-1:0] mml);
		if (int'(mml) > SLOT_BYTES) begin
			return CNT_W'(SLOT_BYTES);
		end
		return CNT_W'(mml);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
			input logic [RING_W-1:0] ring);
		int n;
		n = int'(s) + 1;
		if (n >= int'(ring)) begin
			return '0;
		end
		return SLOT_W'(n);
	endfunction

	function automatic logic [MCNT_W-1:0] queued(input logic [SLOT_W-1:0] w,
			input logic [SLOT_W-1:0] r, input logic [RING_W-1:0] ring);
		int d;
		d = int'(w) - int'(r);
		if (d < 0) begin
			d = d + int'(ring);
		end
		return MCNT_W'(d);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
			input logic [CNT_W-1:0] idx);
		return ADDR_W'(int'(s) * SLOT_BYTES + int'(idx));
	endfunction

endpackage

@@ src/mrq_ram.sv @@
module mrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/mrq_front.sv @@
module mrq_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mrq_pkg::CMD_W-1:0] cmd,
	input logic [mrq_pkg::DATA_W-1:0] data_byte,
	input logic last_byte,
	input logic empty_message,
	input logic [mrq_pkg::LEN_W-1:0] max_bytes,
	output logic busy,
	output logic op_valid,
	output mrq_pkg::op_t op,
	input logic op_ready
);

	import mrq_pkg::*;

	op_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	op_t new_op;
	logic known;
	logic push;
	logic pop;

	always_comb begin
		new_op.kind = OP_SEND;
		new_op.data = data_byte;
		new_op.has_data = !empty_message;
		new_op.close = last_byte;
		new_op.max_bytes = max_bytes;
		known = 1'b1;
		case (cmd)
			CMD_SEND: new_op.kind = OP_SEND;
			CMD_RECV: new_op.kind = OP_RECV;
			CMD_QUERY: new_op.kind = OP_QUERY;
			default: known = 1'b0;
		endcase
	end

	assign busy = (int'(fill_q) == QDEPTH);
	// An unused command is taken off the port but never queued.
	assign push = start && !busy && known;
	assign op_valid = (fill_q != '0);
	assign op = entry_q[rd_ptr_q];
	assign pop = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ src/mrq_back.sv @@
module mrq_back (
	input logic clk,
	input logic arst_n,
	input mrq_pkg::cfg_t cfg,
	input logic cfg_clear,
	input logic op_valid,
	input mrq_pkg::op_t op,
	output logic op_ready,
	output logic result_strobe,
	output logic [mrq_pkg::STATUS_W-1:0] status,
	output logic [mrq_pkg::DATA_W-1:0] out_byte,
	output logic has_byte,
	output logic [mrq_pkg::LEN_W-1:0] message_length,
	output logic [mrq_pkg::MCNT_W-1:0] message_count,
	output logic last_result
);

	import mrq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_STREAM = 1'b1;

	logic state_q, state_d;
	logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
	logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
	logic [CNT_W-1:0] send_cnt_q, send_cnt_d;
	logic reject_q, reject_d;
	logic [SLOT_W-1:0] str_slot_q, str_slot_d;
	logic [CNT_W-1:0] str_idx_q, str_idx_d;
	logic [CNT_W-1:0] str_len_q, str_len_d;
	logic [CNT_W-1:0] lengths_q [SLOT_COUNT];

	logic [RING_W-1:0] ring;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] new_cnt;
	logic [CNT_W-1:0] stored_len;
	logic [SLOT_W-1:0] nxt;
	logic reject_now;
	logic len_we;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic res_v;
	logic [STATUS_W-1:0] res_status;
	logic res_has;
	logic [CNT_W-1:0] res_len;
	logic res_last;

	logic strobe_q;
	logic [STATUS_W-1:0] status_q;
	logic has_q;
	logic [LEN_W-1:0] len_q;
	logic [MCNT_W-1:0] count_q;
	logic last_q;

	assign ring = ring_size(cfg.max_messages);
	assign limit = length_limit(cfg.max_message_length);
	assign op_ready = (state_q == S_IDLE);
	assign stored_len = lengths_q[rd_slot_q];

	always_comb begin
		state_d = state_q;
		rd_slot_d = rd_slot_q;
		wr_slot_d = wr_slot_q;
		send_cnt_d = send_cnt_q;
		reject_d = reject_q;
		str_slot_d = str_slot_q;
		str_idx_d = str_idx_q;
		str_len_d = str_len_q;
		new_cnt = send_cnt_q;
		nxt = next_slot(wr_slot_q, ring);
		reject_now = 1'b0;
		len_we = 1'b0;
		ram_we = 1'b0;
		ram_waddr = slot_addr(wr_slot_q, send_cnt_q);
		ram_re = 1'b0;
		ram_raddr = slot_addr(str_slot_q, str_idx_q);
		res_v = 1'b0;
		res_status = ST_OK;
		res_has = 1'b0;
		res_len = '0;
		res_last = 1'b1;

		if (state_q == S_STREAM) begin
			ram_re = 1'b1;
			res_v = 1'b1;
			res_has = 1'b1;
			res_len = str_len_q;
			res_last = (str_idx_q + 1'b1 == str_len_q);
			str_idx_d = str_idx_q + 1'b1;
			if (res_last) begin
				state_d = S_IDLE;
			end
		end else if (op_valid) begin
			case (op.kind)
				OP_SEND: begin
					if (op.has_data) begin
						if (send_cnt_q >= limit) begin
							reject_now = 1'b1;
						end else begin
							ram_we = 1'b1;
							new_cnt = send_cnt_q + 1'b1;
						end
					end
					if (op.close) begin
						res_v = 1'b1;
						if (reject_q || reject_now) begin
							res_status = ST_TOO_LONG;
						end else if (nxt == rd_slot_q) begin
							res_status = ST_FULL;
						end else begin
							len_we = 1'b1;
							wr_slot_d = nxt;
							res_len = new_cnt;
						end
						send_cnt_d = '0;
						reject_d = 1'b0;
					end else begin
						send_cnt_d = new_cnt;
						reject_d = reject_q || reject_now;
					end
				end
				OP_RECV: begin
					res_v = 1'b1;
					if (rd_slot_q == wr_slot_q) begin
						res_status = ST_EMPTY;
					end else begin
						rd_slot_d = next_slot(rd_slot_q, ring);
						if (int'(stored_len) > int'(op.max_bytes)) begin
							res_status = ST_BUF_SMALL;
							res_len = stored_len;
						end else if (stored_len != '0) begin
							// The first byte is read right away; the rest streams one a cycle.
							ram_re = 1'b1;
							ram_raddr = slot_addr(rd_slot_q, '0);
							res_has = 1'b1;
							res_len = stored_len;
							res_last = (stored_len == CNT_W'(1));
							if (!res_last) begin
								state_d = S_STREAM;
								str_slot_d = rd_slot_q;
								str_idx_d = CNT_W'(1);
								str_len_d = stored_len;
							end
						end
					end
				end
				OP_QUERY: begin
					res_v = 1'b1;
				end
				default: begin
					res_v = 1'b0;
				end
			endcase
		end

		if (cfg_clear) begin
			rd_slot_d = '0;
			wr_slot_d = '0;
			send_cnt_d = '0;
			reject_d = 1'b0;
		end
	end

	mrq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(op.data),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (len_we) begin
			lengths_q[wr_slot_q] <= new_cnt;
		end
		status_q <= res_status;
		has_q <= res_has;
		len_q <= LEN_W'(res_len);
		count_q <= queued(wr_slot_d, rd_slot_d, ring);
		last_q <= res_last;
		str_slot_q <= str_slot_d;
		str_idx_q <= str_idx_d;
		str_len_q <= str_len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_slot_q <= '0;
			wr_slot_q <= '0;
			send_cnt_q <= '0;
			reject_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_slot_q <= rd_slot_d;
			wr_slot_q <= wr_slot_d;
			send_cnt_q <= send_cnt_d;
			reject_q <= reject_d;
			strobe_q <= res_v;
		end
	end

	assign result_strobe = strobe_q;
	assign status = status_q;
	assign has_byte = strobe_q && has_q;
	assign out_byte = (strobe_q && has_q) ? ram_rdata : '0;
	assign message_length = len_q;
	assign message_count = count_q;
	assign last_result = last_q;

	a_stream_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> !(op_valid && op_ready))
		else $error("operation taken while a receive is streaming");

	a_slots_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(rd_slot_q) < int'(ring)) && (int'(wr_slot_q) < int'(ring)))
		else $error("ring pointer outside the configured ring");

	a_stream_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && has_byte && !last_result) |=> (result_strobe && has_byte))
		else $error("received message stopped before its last byte");

endmodule

@@ src/message_ring_queue.sv @@
// Message queue on a ring of up to 16 slots of 64 bytes; one slot stays empty.
// An item is a transfer on start while busy is low; a two-entry command queue
// between the input port and the executor raises busy when both entries are taken.
// The executor handles one send byte, one send close or one query per cycle
// unless a receive streams; a receive gets one slot-RAM read per byte. A result
// appears on the result ports for one cycle with result_strobe high, after the
// command queue and the result registers; the receiver cannot stall, so every
// strobe is a completed transfer. Results of one item come in consecutive cycles.
// Any register write empties the queue and drops a send in progress; write
// registers only while no command is queued or executing.
module message_ring_queue (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [mrq_pkg::CMD_W-1:0] cmd,
	input logic [mrq_pkg::DATA_W-1:0] data_byte,
	input logic last_byte,
	input logic empty_message,
	input logic [mrq_pkg::LEN_W-1:0] max_bytes,
	output logic result_strobe,
	output logic [mrq_pkg::STATUS_W-1:0] status,
	output logic [mrq_pkg::DATA_W-1:0] out_byte,
	output logic has_byte,
	output logic [mrq_pkg::LEN_W-1:0] message_length,
	output logic [mrq_pkg::MCNT_W-1:0] message_count,
	output logic last_result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	import mrq_pkg::*;

	localparam logic REG_MAX_MESSAGES = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	cfg_t cfg_q;
	logic cfg_write;
	logic op_valid;
	logic op_ready;
	op_t op;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_messages <= MMSG_W'(15);
			cfg_q.max_message_length <= LEN_W'(64);
		end else if (cfg_write) begin
			case (paddr[2])
				REG_MAX_MESSAGES: cfg_q.max_messages <= pwdata[MMSG_W-1:0];
				REG_MAX_LENGTH: cfg_q.max_message_length <= pwdata[LEN_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_MESSAGES: prdata = 32'(cfg_q.max_messages);
			REG_MAX_LENGTH: prdata = 32'(cfg_q.max_message_length);
			default: prdata = '0;
		endcase
	end

	mrq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty_message(empty_message),
		.max_bytes(max_bytes),
		.busy(busy),
		.op_valid(op_valid),
		.op(op),
		.op_ready(op_ready)
	);

	mrq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cfg_clear(cfg_write),
		.op_valid(op_valid),
		.op(op),
		.op_ready(op_ready),
		.result_strobe(result_strobe),
		.status(status),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.message_length(message_length),
		.message_count(message_count),
		.last_result(last_result)
	);

endmodule

@@ tb/message_ring_queue_tb.sv @@
module message_ring_queue_tb;
	import mrq_pkg::*;

	localparam int REG_MAX_MESSAGES = 0;
	localparam int REG_MAX_LENGTH = 1;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 380;
	localparam int PHASE_ITEMS = 60;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0] out_byte;
		logic has_byte;
		logic [LEN_W-1:0] message_length;
		logic [MCNT_W-1:0] message_count;
		logic last_result;
	} queue_result_t;

	class ring_queue_scoreboard;
		logic [DATA_W-1:0] slot_data [SLOT_COUNT*SLOT_BYTES];
		logic [LEN_W-1:0] slot_len [SLOT_COUNT];
		int unsigned rd_slot;
		int unsigned wr_slot;
		int unsigned send_len;
		bit send_overflow;
		int unsigned cfg_max_messages;
		int unsigned cfg_max_length;
		queue_result_t expected_results[$];
		int mismatches;

		function new();
			cfg_max_messages = 15;
			cfg_max_length = 64;
			mismatches = 0;
			clear_ring();
		endfunction

		function void clear_ring();
			rd_slot = 0;
			wr_slot = 0;
			send_len = 0;
			send_overflow = 1'b0;
		endfunction

		// Any register write also empties the ring and drops a send in progress.
		function void write_register(int unsigned idx, logic [31:0] value);
			if (idx == REG_MAX_MESSAGES) begin
				cfg_max_messages = value[3:0];
			end else if (idx == REG_MAX_LENGTH) begin
				cfg_max_length = value[6:0];
			end
			clear_ring();
		endfunction

		function int unsigned ring_slots();
			return (cfg_max_messages + 1 > SLOT_COUNT) ? SLOT_COUNT : cfg_max_messages + 1;
		endfunction

		function int unsigned queued_count();
			return (wr_slot + ring_slots() - rd_slot) % ring_slots();
		endfunction

		function void add_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] ob, bit has,
				int unsigned len, bit last);
			queue_result_t r;
			r.status = st;
			r.out_byte = ob;
			r.has_byte = has;
			r.message_length = LEN_W'(len);
			r.message_count = MCNT_W'(queued_count());
			r.last_result = last;
			expected_results.push_back(r);
		endfunction

		function void note_item(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d, logic lb,
				logic em, logic [LEN_W-1:0] mb);
			int unsigned limit;
			int unsigned nxt;
			int unsigned len;
			int unsigned base;
			limit = (cfg_max_length > SLOT_BYTES) ? SLOT_BYTES : cfg_max_length;
			case (c)
				CMD_SEND: begin
					if (!em) begin
						if (send_len >= limit) begin
							send_overflow = 1'b1;
						end else begin
							slot_data[wr_slot*SLOT_BYTES + send_len] = d;
							send_len++;
						end
					end
					if (lb) begin
						nxt = (wr_slot + 1 >= ring_slots()) ? 0 : wr_slot + 1;
						// The length check wins over the full check.
						if (send_overflow) begin
							add_result(ST_TOO_LONG, '0, 1'b0, 0, 1'b1);
						end else if (nxt == rd_slot) begin
							add_result(ST_FULL, '0, 1'b0, 0, 1'b1);
						end else begin
							slot_len[wr_slot] = LEN_W'(send_len);
							wr_slot = nxt;
							add_result(ST_OK, '0, 1'b0, send_len, 1'b1);
						end
						send_len = 0;
						send_overflow = 1'b0;
					end
				end
				CMD_RECV: begin
					if (rd_slot == wr_slot) begin
						add_result(ST_EMPTY, '0, 1'b0, 0, 1'b1);
					end else begin
						base = rd_slot * SLOT_BYTES;
						len = slot_len[rd_slot];
						rd_slot = (rd_slot + 1 >= ring_slots()) ? 0 : rd_slot + 1;
						if (len > mb) begin
							add_result(ST_BUF_SMALL, '0, 1'b0, len, 1'b1);
						end else if (len == 0) begin
							add_result(ST_OK, '0, 1'b0, 0, 1'b1);
						end else begin
							for (int i = 0; i < len; i++) begin
								add_result(ST_OK, slot_data[base + i], 1'b1, len, i + 1 == len);
							end
						end
					end
				end
				CMD_QUERY: begin
					add_result(ST_OK, '0, 1'b0, 0, 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: status %0d byte %02h has %0b len %0d count %0d last %0b",
						got.status, got.out_byte, got.has_byte, got.message_length,
						got.message_count, got.last_result);
				end
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status || got.out_byte !== want.out_byte ||
					got.has_byte !== want.has_byte || got.message_length !== want.message_length ||
					got.message_count !== want.message_count ||
					got.last_result !== want.last_result) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected status %0d byte %02h has %0b len %0d count %0d last %0b",
						want.status, want.out_byte, want.has_byte, want.message_length,
						want.message_count, want.last_result);
					$display("          got      status %0d byte %02h has %0b len %0d count %0d last %0b",
						got.status, got.out_byte, got.has_byte, got.message_length,
						got.message_count, got.last_result);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [CMD_W-1:0] cmd;
	logic [DATA_W-1:0] data_byte;
	logic last_byte;
	logic empty_message;
	logic [LEN_W-1:0] max_bytes;
	logic result_strobe;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0] out_byte;
	logic has_byte;
	logic [LEN_W-1:0] message_length;
	logic [MCNT_W-1:0] message_count;
	logic last_result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ring_queue_scoreboard sb = new();
	int unsigned items_done = 0;
	bit gaps_on = 1'b1;

	message_ring_queue u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	// The receiver cannot stall, so every strobe is a completed transfer.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			sb.check_result({status, out_byte, has_byte, message_length, message_count,
				last_result});
		end
	end

	function automatic logic [LEN_W-1:0] rand_buffer();
		if ($urandom_range(0, 9) < 6) begin
			return LEN_W'($urandom_range(64, 127));
		end
		return LEN_W'($urandom_range(0, 10));
	endfunction

	task automatic drive_item(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] d,
			input logic lb, input logic em, input logic [LEN_W-1:0] mb);
		int unsigned gap;
		start <= 1'b1;
		cmd <= c;
		data_byte <= d;
		last_byte <= lb;
		empty_message <= em;
		max_bytes <= mb;
		do @(posedge clk); while (busy);
		sb.note_item(c, d, lb, em, mb);
		if (c != CMD_UNUSED) begin
			items_done++;
		end
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		// With no gap, start stays high and the next call drives the next transfer.
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message(input int unsigned n, input bit noisy);
		bit close_empty;
		close_empty = noisy && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0: drive_item(CMD_SEND, DATA_W'($urandom), 1'b0, 1'b1, LEN_W'($urandom));
					1: drive_item(CMD_QUERY, DATA_W'($urandom), 1'b0, 1'b0, LEN_W'($urandom));
					default: drive_item(CMD_UNUSED, DATA_W'($urandom), 1'b1, 1'b0, LEN_W'($urandom));
				endcase
			end
			drive_item(CMD_SEND, DATA_W'($urandom), (i == n - 1) && !close_empty, 1'b0,
				LEN_W'($urandom));
		end
		if (n == 0 || close_empty) begin
			drive_item(CMD_SEND, DATA_W'($urandom), 1'b1, 1'b1, LEN_W'($urandom));
		end
	endtask

	task automatic send_bytes(input logic [DATA_W-1:0] b0, input logic [DATA_W-1:0] b1,
			input logic [DATA_W-1:0] b2, input int unsigned n);
		if (n > 0) drive_item(CMD_SEND, b0, n == 1, 1'b0, '0);
		if (n > 1) drive_item(CMD_SEND, b1, n == 2, 1'b0, '1);
		if (n > 2) drive_item(CMD_SEND, b2, 1'b1, 1'b0, '0);
	endtask

	task automatic settle_queue();
		start <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		// Sends without a close and unused commands leave nothing to wait on.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input int unsigned idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_register(idx, value);
	endtask

	initial begin
		int unsigned phase;
		int unsigned cfg_msgs;
		int unsigned cfg_len;
		int unsigned limit;
		int unsigned n;
		int unsigned pick;
		int unsigned phase_end;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_SEND;
		data_byte = '0;
		last_byte = 1'b0;
		empty_message = 1'b0;
		max_bytes = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset configuration.
		drive_item(CMD_RECV, 8'hFF, 1'b1, 1'b1, 7'd0);
		drive_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 7'd127);
		drive_item(CMD_SEND, 8'hFF, 1'b1, 1'b1, 7'd0);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd0);
		drive_item(CMD_SEND, 8'h00, 1'b0, 1'b0, 7'd0);
		drive_item(CMD_SEND, 8'hFF, 1'b0, 1'b0, 7'd64);
		drive_item(CMD_SEND, 8'h3C, 1'b0, 1'b1, 7'd0);
		drive_item(CMD_SEND, 8'hA5, 1'b1, 1'b0, 7'd0);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd2);
		drive_item(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 7'd127);
		send_bytes(8'h5A, 8'hC3, 8'h7F, 3);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd127);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd64);

		settle_queue();
		write_register(REG_MAX_MESSAGES, 1);
		write_register(REG_MAX_LENGTH, 2);
		send_bytes(8'h11, 8'h22, 8'h33, 3);
		send_bytes(8'h80, 8'h01, 8'h00, 2);
		drive_item(CMD_SEND, 8'h00, 1'b1, 1'b1, 7'd0);
		drive_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 7'd0);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd2);

		settle_queue();
		write_register(REG_MAX_MESSAGES, 0);
		write_register(REG_MAX_LENGTH, 0);
		drive_item(CMD_SEND, 8'h00, 1'b1, 1'b1, 7'd0);
		drive_item(CMD_SEND, 8'h42, 1'b1, 1'b0, 7'd0);
		drive_item(CMD_RECV, 8'h00, 1'b0, 1'b0, 7'd127);

		phase = 0;
		while (items_done < ITEM_TARGET) begin
			settle_queue();
			case (phase)
				0: begin cfg_msgs = 15; cfg_len = 64; end
				1: begin cfg_msgs = 3; cfg_len = 12; end
				2: begin cfg_msgs = 1; cfg_len = 0; end
				3: begin cfg_msgs = 15; cfg_len = 127; end
				4: begin cfg_msgs = 0; cfg_len = 5; end
				5: begin cfg_msgs = 7; cfg_len = 100; end
				6: begin cfg_msgs = 2; cfg_len = 64; end
				default: begin
					cfg_msgs = $urandom_range(0, 15);
					cfg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127)
						: $urandom_range(0, 64);
				end
			endcase
			write_register(REG_MAX_MESSAGES, cfg_msgs);
			write_register(REG_MAX_LENGTH, cfg_len);
			gaps_on = $urandom_range(0, 2) != 0;
			limit = (cfg_len > SLOT_BYTES) ? SLOT_BYTES : cfg_len;
			phase_end = items_done + PHASE_ITEMS;
			if (phase_end > ITEM_TARGET) begin
				phase_end = ITEM_TARGET;
			end
			while (items_done < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 52) begin
					pick = $urandom_range(0, 99);
					if (pick < 80) begin
						n = $urandom_range(0, 6);
					end else if (pick < 92) begin
						// Lengths around the limit reach the too-long case.
						n = limit + $urandom_range(0, 2);
						if (n > 0) n = n - 1;
					end else begin
						n = $urandom_range(0, SLOT_BYTES + 2);
					end
					send_message(n, $urandom_range(0, 9) == 0);
				end else if (pick < 82) begin
					drive_item(CMD_RECV, DATA_W'($urandom), 1'($urandom), 1'($urandom),
						rand_buffer());
				end else if (pick < 92) begin
					drive_item(CMD_QUERY, DATA_W'($urandom), 1'($urandom), 1'($urandom),
						LEN_W'($urandom));
				end else if (pick < 96) begin
					drive_item(CMD_UNUSED, DATA_W'($urandom), 1'($urandom), 1'($urandom),
						LEN_W'($urandom));
				end else begin
					settle_queue();
				end
			end
			phase++;
		end

		settle_queue();
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/mrq_pkg.sv
src/mrq_ram.sv
src/mrq_front.sv
src/mrq_back.sv
src/message_ring_queue.sv
tb/message_ring_queue_tb.sv
